@@ src/obp_pkg.sv @@
// Shared constants and a saturating-add function for the order book pressure unit.
package obp_pkg;
  localparam int LEVEL_COUNT = 1024;
  localparam int LEVEL_W = $clog2(LEVEL_COUNT);
  localparam int VOL_W = 63;
  localparam logic [VOL_W-1:0] MAX63 = {VOL_W{1'b1}};
  localparam logic [63:0] RESET_LOW_PRICE = 64'd10000;
  localparam logic [63:0] RESET_HIGH_PRICE = 64'd11000;
  localparam logic [7:0] SIDE_BID = 8'd66;
  localparam logic [7:0] SIDE_ASK = 8'd83;
  localparam logic [0:0] REG_LOW_PRICE = 1'b0;
  localparam logic [0:0] REG_HIGH_PRICE = 1'b1;
  localparam logic [16:0] SHARE_HALF = 17'd32768;
  // Divider: 80-bit dividend (bid shifted left by 16), one quotient bit a cycle.
  localparam int DIV_STEPS = 80;
  localparam int DIV_CNT_W = 7;

  // Saturating 63-bit add of a 63-bit value.
  function automatic logic [VOL_W-1:0] sat_add(input logic [VOL_W-1:0] a,
                                               input logic [VOL_W-1:0] b);
    logic [VOL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VOL_W] ? MAX63 : s[VOL_W-1:0];
  endfunction
endpackage

@@ src/obp_ram.sv @@
// Generic simple dual-port synchronous RAM (one write port, one read port) with registered read.
module obp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ src/obp_div.sv @@
// Restoring divider: floor(bid * 2^16 / total) for share and floor(diff * 20 / total) for pressure, one bit per cycle.
module obp_div
  import obp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [VOL_W-1:0]     bid,
  input  logic [VOL_W-1:0]     ask,
  output logic                 done,
  output logic [16:0]          share,
  output logic [5:0]           pressure
);
  // Two divisions share the total: bid*65536/total and diff*20/total.
  logic [VOL_W:0]     total;
  logic [VOL_W-1:0]   diff;
  logic               neg;
  logic [79:0]        num_a;  // bid << 16
  logic [67:0]        num_b;  // diff * 20
  logic [VOL_W+1:0]   rem_a, rem_b;
  logic [16:0]        q_a;
  logic [4:0]         q_b;
  logic [DIV_CNT_W:0] cnt;
  logic               busy;
  logic               zero;
  logic [VOL_W+1:0]   ta, tb;

  always_comb begin
    ta = {rem_a[VOL_W:0], num_a[79]};
    tb = {rem_b[VOL_W:0], num_b[67]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= (DIV_CNT_W+1)'(DIV_STEPS);
        total <= {1'b0, bid} + {1'b0, ask};
        zero <= (bid == '0) && (ask == '0);
        neg <= ask > bid;
        diff <= (ask > bid) ? ask - bid : bid - ask;
        num_a <= {1'b0, bid, 16'd0};
        num_b <= '0;
        rem_a <= '0;
        rem_b <= '0;
        q_a <= '0;
        q_b <= '0;
      end else if (busy) begin
        if (cnt == (DIV_CNT_W+1)'(DIV_STEPS)) begin
          num_b <= {5'd0, diff} * 68'd20;
        end
        num_a <= num_a << 1;
        if (cnt <= 8'd68) num_b <= num_b << 1;
        if (ta >= {1'b0, total}) begin
          rem_a <= ta - {1'b0, total};
          q_a <= {q_a[15:0], 1'b1};
        end else begin
          rem_a <= ta;
          q_a <= {q_a[15:0], 1'b0};
        end
        if (cnt <= 8'd68) begin
          if (tb >= {1'b0, total}) begin
            rem_b <= tb - {1'b0, total};
            q_b <= {q_b[3:0], 1'b1};
          end else begin
            rem_b <= tb;
            q_b <= {q_b[3:0], 1'b0};
          end
        end
        cnt <= cnt - 8'd1;
        if (cnt == 8'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    share = zero ? SHARE_HALF : q_a;
    pressure = zero ? 6'd0 : (neg ? 6'd0 - {1'b0, q_b} : {1'b0, q_b});
  end
endmodule

@@ src/order_book_pressure_unit.sv @@
// Top level of the order book pressure unit.
//   channel | signals                           | dir
//   in      | in_valid/in_ready price volume side | in
//   out     | out_valid/out_ready in_range..pressure | out
//   cfg     | cfg_we cfg_index cfg_data           | in
// After reset a clearing pass writes zero to all 1024 levels.
// Each order goes through accept (S_IDLE), RAM read (S_READ), update
// (S_UPD), bit-serial division (S_DIV) and the result (S_OUT) states.
// out_valid is high in S_OUT.
// One order at a time; the result register holds while out_ready is low.
module order_book_pressure_unit
  import obp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [63:0] price,
  input  logic [31:0]        volume,
  input  logic [7:0]         side,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               in_range,
  output logic [62:0]        level_bid,
  output logic [62:0]        level_ask,
  output logic [62:0]        total_bid,
  output logic [62:0]        total_ask,
  output logic [16:0]        bid_share,
  output logic signed [5:0]  pressure,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  localparam logic [2:0] S_CLEAR = 3'd0, S_IDLE = 3'd1, S_READ = 3'd2,
                         S_UPD = 3'd3, S_DIV = 3'd4, S_OUT = 3'd5;
  logic [2:0] state;
  logic signed [63:0] low_price, high_price;
  logic [LEVEL_W:0] clr;
  logic [LEVEL_W-1:0] addr;
  logic [7:0] side_r;
  logic [31:0] vol_r;
  logic hit;
  logic [VOL_W-1:0] bid_rd, ask_rd, bid_new, ask_new;
  logic bid_we, ask_we;
  logic [LEVEL_W-1:0] waddr;
  logic [VOL_W-1:0] bid_wd, ask_wd;
  logic div_start, div_done;
  logic [16:0] share_w;
  logic [5:0] pres_w;
  logic [64:0] off;
  logic in_win;

  // Range check on the incoming order
  always_comb begin
    off = {price[63], price} - {low_price[63], low_price};
    in_win = (price >= low_price) && (price <= high_price)
             && (off < 65'(LEVEL_COUNT));
  end

  always_comb begin
    bid_new = sat_add(bid_rd, {31'd0, vol_r});
    ask_new = sat_add(ask_rd, {31'd0, vol_r});
    waddr = (state == S_CLEAR) ? clr[LEVEL_W-1:0] : addr;
    bid_we = (state == S_CLEAR) || (state == S_UPD && hit && side_r == SIDE_BID);
    ask_we = (state == S_CLEAR) || (state == S_UPD && hit && side_r == SIDE_ASK);
    bid_wd = (state == S_CLEAR) ? '0 : bid_new;
    ask_wd = (state == S_CLEAR) ? '0 : ask_new;
  end

  obp_ram #(.WIDTH(VOL_W), .DEPTH(LEVEL_COUNT)) u_bid (
    .clk, .we(bid_we), .waddr, .wdata(bid_wd), .raddr(addr), .rdata(bid_rd));
  obp_ram #(.WIDTH(VOL_W), .DEPTH(LEVEL_COUNT)) u_ask (
    .clk, .we(ask_we), .waddr, .wdata(ask_wd), .raddr(addr), .rdata(ask_rd));

  assign div_start = (state == S_UPD);
  obp_div u_div (.clk, .rst, .start(div_start),
    .bid(hit && side_r == SIDE_BID ? sat_add(total_bid, bid_new - bid_rd) : total_bid),
    .ask(hit && side_r == SIDE_ASK ? sat_add(total_ask, ask_new - ask_rd) : total_ask),
    .done(div_done), .share(share_w), .pressure(pres_w));

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      low_price <= RESET_LOW_PRICE;
      high_price <= RESET_HIGH_PRICE;
    end else if (cfg_we) begin
      if (cfg_index == REG_LOW_PRICE) low_price <= cfg_data;
      else high_price <= cfg_data;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      total_bid <= '0;
      total_ask <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (LEVEL_W+1)'(LEVEL_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          addr <= off[LEVEL_W-1:0];
          hit <= in_win;
          side_r <= side;
          vol_r <= volume;
          state <= S_READ;
        end
        S_READ: state <= S_UPD;
        S_UPD: begin
          in_range <= hit;
          level_bid <= hit ? (side_r == SIDE_BID ? bid_new : bid_rd) : '0;
          level_ask <= hit ? (side_r == SIDE_ASK ? ask_new : ask_rd) : '0;
          if (hit && side_r == SIDE_BID) total_bid <= sat_add(total_bid, bid_new - bid_rd);
          if (hit && side_r == SIDE_ASK) total_ask <= sat_add(total_ask, ask_new - ask_rd);
          state <= S_DIV;
        end
        S_DIV: if (div_done) begin
          bid_share <= share_w;
          pressure <= pres_w;
          state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
